// ----- hw/rtl/irm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants of the ICMP reply matcher: transaction payloads,
// status codes, register indexes and header geometry.
// ----------------------------------------------------------------------------
package irm_pkg;

   // byte position counter width, holds up to 2047
   localparam int POS_W            = 11;
   localparam int POS_LIMIT        = 2047;
   localparam int MAX_PACKET_BYTES = 1024;

   // header geometry in bytes
   localparam int ICMP_HDR_BYTES = 8;
   localparam int ID_OFFSET      = 4;
   localparam int SRC_FIRST      = 12;
   localparam int SRC_LAST       = 15;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EXPECTED_ID        = 3'd0,
      CSR_EXPECTED_SEQ       = 3'd1,
      CSR_SEND_TIME          = 3'd2,
      CSR_ECHO_REPLY_TYPE    = 3'd3,
      CSR_TIME_EXCEEDED_TYPE = 3'd4
   } csr_index_type;

   localparam logic [7:0] TIME_EXCEEDED_RESET = 8'd11;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_OTHER     = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic        matched;
      logic        was_time_exceeded;
      logic [31:0] source_ip;
      logic [31:0] round_trip_ms;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/icmp_reply_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp_reply_matcher
// Parses a received IPv4 packet byte by byte and reports ICMP reply status,
// id/sequence match, source address and round trip time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packet byte per transaction, starting at the outer IP
//   header; last_byte marks the final byte, now_ms is sampled there.
//   rsp_* carries one result per packet, valid in the cycle after the final byte is
//   accepted. csr_* writes the expected id/sequence, send time and the two
//   ICMP type codes; write only while no packet is in progress.
//   Throughput: one byte per cycle while req_ready is high. The per-byte work
//   (position compares, capture, header length adds and the round trip
//   subtract) sits between the packet state registers and the result register.
//   The result register is freed the same cycle it is taken, so req_ready
//   stays high unless a result is held and rsp_ready is low; a stalled
//   receiver holds the result and stops byte intake only in that case.
//   Reset clears the packet state and the result valid flag and loads the
//   register defaults (time exceeded type 11, others zero).
//   Bytes beyond MAX_BYTES (capped at 2047) are ignored until last.
// ----------------------------------------------------------------------------
module icmp_reply_matcher
   import irm_pkg::*;
#(
   parameter int MAX_BYTES = MAX_PACKET_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int POS_CAP = (MAX_BYTES < POS_LIMIT) ? MAX_BYTES : POS_LIMIT;
   localparam logic [POS_W-1:0] CAP_VAL = POS_W'(POS_CAP);

   // configuration registers
   logic [15:0] expected_id_ff;
   logic [15:0] expected_seq_ff;
   logic [31:0] send_time_ff;
   logic [7:0]  echo_type_ff;
   logic [7:0]  te_type_ff;

   // packet state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [5:0]       outer_len_ff, outer_len_in;
   logic [7:0]       msg_type_ff, msg_type_in;
   logic [5:0]       inner_len_ff, inner_len_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      source_ff, source_in;
   logic [1:0]       seen_ff, seen_in;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic             accept;
   logic             take;
   logic [7:0]       b;
   logic [POS_W-1:0] h_ext;
   logic [POS_W-1:0] h_icmp_end;
   logic [POS_W-1:0] base;
   logic [POS_W-1:0] off;
   logic             have_base;
   logic             is_echo;
   logic             is_te;
   status_type       status;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign b           = req_payload.data_byte;
   assign take        = pos_ff < CAP_VAL;

   // per-byte capture
   always_comb begin
      outer_len_in = outer_len_ff;
      msg_type_in  = msg_type_ff;
      inner_len_in = inner_len_ff;
      id_in        = id_ff;
      seq_in       = seq_ff;
      source_in    = source_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      have_base    = 1'b0;
      base         = '0;
      off          = '0;
      h_ext        = POS_W'(outer_len_ff);
      h_icmp_end   = h_ext + POS_W'(ICMP_HDR_BYTES);
      if (take) begin
         if (pos_ff == '0) begin
            outer_len_in = {b[3:0], 2'b00};
         end
         h_ext      = POS_W'(outer_len_in);
         h_icmp_end = h_ext + POS_W'(ICMP_HDR_BYTES);
         if (pos_ff >= POS_W'(SRC_FIRST) && pos_ff <= POS_W'(SRC_LAST)) begin
            source_in = {source_ff[23:0], b};
         end
         if (pos_ff == h_ext) begin
            msg_type_in = b;
         end
         if (pos_ff == h_icmp_end) begin
            inner_len_in = {b[3:0], 2'b00};
         end
         // locate the id/sequence field
         if (pos_ff > h_ext && msg_type_in == echo_type_ff) begin
            have_base = 1'b1;
            base      = h_ext + POS_W'(ID_OFFSET);
         end else if (pos_ff > h_icmp_end && msg_type_in == te_type_ff) begin
            have_base = 1'b1;
            base      = h_icmp_end + POS_W'(inner_len_in) + POS_W'(ID_OFFSET);
         end
         off = pos_ff - base;
         if (have_base && pos_ff >= base) begin
            case (off)
               POS_W'(0): id_in[15:8] = b;
               POS_W'(1): begin
                  id_in[7:0] = b;
                  seen_in[0] = 1'b1;
               end
               POS_W'(2): seq_in[15:8] = b;
               POS_W'(3): begin
                  seq_in[7:0] = b;
                  seen_in[1] = 1'b1;
               end
               default: ;
            endcase
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // result of the packet from the updated state
   always_comb begin
      is_echo = msg_type_in == echo_type_ff;
      is_te   = !is_echo && msg_type_in == te_type_ff;
      if (pos_in < POS_W'(outer_len_in) + POS_W'(ICMP_HDR_BYTES)) begin
         status = STATUS_SHORT;
      end else if (!is_echo && !is_te) begin
         status = STATUS_OTHER;
      end else if (seen_in != 2'b11) begin
         status = STATUS_TRUNCATED;
      end else begin
         status = STATUS_OK;
      end
      rsp_in.status            = status;
      rsp_in.matched           = (status == STATUS_OK) && id_in == expected_id_ff
                                 && seq_in == expected_seq_ff;
      rsp_in.was_time_exceeded = (status == STATUS_OK || status == STATUS_TRUNCATED)
                                 && is_te;
      rsp_in.source_ip         = source_in;
      rsp_in.round_trip_ms     = req_payload.now_ms - send_time_ff;
   end

   // packet state, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset || (accept && req_payload.last_byte)) begin
         pos_ff       <= '0;
         outer_len_ff <= '0;
         msg_type_ff  <= '0;
         inner_len_ff <= '0;
         id_ff        <= '0;
         seq_ff       <= '0;
         source_ff    <= '0;
         seen_ff      <= '0;
      end else if (accept) begin
         pos_ff       <= pos_in;
         outer_len_ff <= outer_len_in;
         msg_type_ff  <= msg_type_in;
         inner_len_ff <= inner_len_in;
         id_ff        <= id_in;
         seq_ff       <= seq_in;
         source_ff    <= source_in;
         seen_ff      <= seen_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_payload.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff  <= '0;
         expected_seq_ff <= '0;
         send_time_ff    <= '0;
         echo_type_ff    <= '0;
         te_type_ff      <= TIME_EXCEEDED_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EXPECTED_ID:        expected_id_ff  <= csr_wdata[15:0];
            CSR_EXPECTED_SEQ:       expected_seq_ff <= csr_wdata[15:0];
            CSR_SEND_TIME:          send_time_ff    <= csr_wdata[31:0];
            CSR_ECHO_REPLY_TYPE:    echo_type_ff    <= csr_wdata[7:0];
            CSR_TIME_EXCEEDED_TYPE: te_type_ff      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // a match is only reported for a complete, recognized reply
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.matched || rsp_ff.status == STATUS_OK))
      else $error("match flagged on a bad status");

   // short or unrecognized packets never report time exceeded
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STATUS_SHORT || rsp_ff.status == STATUS_OTHER)
      |-> !rsp_ff.was_time_exceeded)
      else $error("time exceeded flagged on a short or other packet");

   // the final byte clears packet state and raises a result
   assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.last_byte |=> rsp_valid_ff && pos_ff == '0 && seen_ff == 2'b00)
      else $error("final byte did not produce a result and clear state");

   // the position counter never runs past the cap
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= CAP_VAL)
      else $error("byte position beyond cap");

endmodule

// ----- verif/tb_icmp_reply_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_icmp_reply_matcher
// Self-checking bench for the ICMP reply matcher. Packets are built as echo
// replies, time exceeded messages, other types and random noise. Each packet
// may be cut short or padded out. They are fed one byte per transaction,
// with random gaps on both sides. A byte-level parser in the bench predicts
// each result, and every result is compared field by field in arrival order.
// Several register settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module tb_icmp_reply_matcher;
   import irm_pkg::*;

   localparam int HDR_WORD_BYTES = 4;
   localparam int POS_CAP        = (MAX_PACKET_BYTES < POS_LIMIT) ? MAX_PACKET_BYTES
                                                                  : POS_LIMIT;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_AT_RESULT = 8;
   localparam int HOLD_CYCLES    = 300;

   typedef enum {PKT_ECHO, PKT_TIME_EXCEEDED, PKT_OTHER, PKT_NOISE} pkt_kind_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   // bytes waiting to be driven and results still owed by the block
   req_payload_type pending_bytes[$];
   rsp_payload_type expected_replies[$];
   int              error_count = 0;

   // register copies
   logic [15:0] want_id       = '0;
   logic [15:0] want_seq      = '0;
   logic [31:0] probe_sent_ms = '0;
   logic [7:0]  echo_code     = '0;
   logic [7:0]  ttl_code      = TIME_EXCEEDED_RESET;

   // per-packet parse state
   int          rx_pos;
   int          rx_outer_len;
   logic [7:0]  rx_type;
   int          rx_inner_len;
   logic [15:0] rx_id;
   logic [15:0] rx_seq;
   logic [31:0] rx_source;
   logic [1:0]  rx_fields;

   // driver and monitor bookkeeping
   rsp_payload_type predicted_reply;
   rsp_payload_type reply_want;
   int              gap_left        = 0;
   int              req_calm        = 0;
   int              stall_left      = 0;
   int              hold_left       = 0;
   int              rsp_calm        = 0;
   int              results_checked = 0;
   bit              long_hold_done  = 1'b0;

   icmp_reply_matcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_packet_state();
      rx_pos       = 0;
      rx_outer_len = 0;
      rx_type      = '0;
      rx_inner_len = 0;
      rx_id        = '0;
      rx_seq       = '0;
      rx_source    = '0;
      rx_fields    = '0;
   endfunction

   // parse one byte, returns 1 with the reply when the byte closes a packet
   function automatic bit parse_reply_byte(input req_payload_type item,
                                           output rsp_payload_type reply);
      int base;
      bit have_base;
      bit is_echo;
      bit is_te;
      reply = '0;
      if (rx_pos < POS_CAP) begin
         if (rx_pos == 0)
            rx_outer_len = int'(item.data_byte[3:0]) * HDR_WORD_BYTES;
         if (rx_pos >= SRC_FIRST && rx_pos <= SRC_LAST)
            rx_source = {rx_source[23:0], item.data_byte};
         if (rx_pos == rx_outer_len)
            rx_type = item.data_byte;
         if (rx_pos == rx_outer_len + ICMP_HDR_BYTES)
            rx_inner_len = int'(item.data_byte[3:0]) * HDR_WORD_BYTES;

         // where id and sequence start for this message type
         have_base = 1'b1;
         base      = 0;
         if (rx_pos > rx_outer_len && rx_type == echo_code)
            base = rx_outer_len + ID_OFFSET;
         else if (rx_pos > rx_outer_len + ICMP_HDR_BYTES && rx_type == ttl_code)
            base = rx_outer_len + ICMP_HDR_BYTES + rx_inner_len + ID_OFFSET;
         else
            have_base = 1'b0;

         if (have_base && rx_pos >= base) begin
            case (rx_pos - base)
               0: rx_id[15:8] = item.data_byte;
               1: begin
                  rx_id[7:0]   = item.data_byte;
                  rx_fields[0] = 1'b1;
               end
               2: rx_seq[15:8] = item.data_byte;
               3: begin
                  rx_seq[7:0]  = item.data_byte;
                  rx_fields[1] = 1'b1;
               end
               default: ;
            endcase
         end
         rx_pos++;
      end
      if (!item.last_byte)
         return 1'b0;

      // close the packet
      is_echo = (rx_type == echo_code);
      is_te   = !is_echo && (rx_type == ttl_code);
      if (rx_pos < rx_outer_len + ICMP_HDR_BYTES)
         reply.status = STATUS_SHORT;
      else if (!is_echo && !is_te)
         reply.status = STATUS_OTHER;
      else if (rx_fields != 2'b11)
         reply.status = STATUS_TRUNCATED;
      else
         reply.status = STATUS_OK;
      reply.was_time_exceeded = is_te &&
         (reply.status == STATUS_OK || reply.status == STATUS_TRUNCATED);
      reply.matched = (reply.status == STATUS_OK) && rx_id == want_id && rx_seq == want_seq;
      reply.source_ip     = rx_source;
      reply.round_trip_ms = item.now_ms - probe_sent_ms;
      clear_packet_state();
      return 1'b1;
   endfunction

   // idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm_left);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_EXPECTED_ID:        want_id       = value[15:0];
         CSR_EXPECTED_SEQ:       want_seq      = value[15:0];
         CSR_SEND_TIME:          probe_sent_ms = value;
         CSR_ECHO_REPLY_TYPE:    echo_code     = value[7:0];
         CSR_TIME_EXCEEDED_TYPE: ttl_code      = value[7:0];
         default: ;
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] value, input bit last);
      req_payload_type item;
      item.data_byte = value;
      item.last_byte = last;
      item.now_ms    = $urandom;
      if (last) begin
         case ($urandom_range(0, 9))
            0: item.now_ms = probe_sent_ms;
            1: item.now_ms = probe_sent_ms - 1;
            2: item.now_ms = '0;
            3: item.now_ms = '1;
            default: ;
         endcase
      end
      pending_bytes.push_back(item);
   endtask

   // build one packet of the given kind, padded by extra bytes or cut short
   task automatic queue_packet(input pkt_kind_type kind, input int extra, input bit cut);
      logic [7:0]  pkt [];
      logic [15:0] id_val;
      logic [15:0] seq_val;
      logic [3:0]  hdr_nib;
      logic [3:0]  inner_nib;
      int          hdr_len;
      int          inner_len;
      int          id_at;
      int          full_len;
      int          total;
      int          i;
      hdr_nib   = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(0, 15));
      inner_nib = $urandom_range(0, 1) ? 4'd5 : 4'($urandom_range(0, 15));
      hdr_len   = int'(hdr_nib) * HDR_WORD_BYTES;
      inner_len = int'(inner_nib) * HDR_WORD_BYTES;
      id_val    = ($urandom_range(0, 3) != 0) ? want_id : 16'($urandom);
      seq_val   = ($urandom_range(0, 3) != 0) ? want_seq : 16'($urandom);
      case (kind)
         PKT_TIME_EXCEEDED: full_len = hdr_len + 2 * ICMP_HDR_BYTES + inner_len;
         PKT_NOISE:         full_len = $urandom_range(1, 40);
         default:           full_len = hdr_len + ICMP_HDR_BYTES;
      endcase
      pkt = new[full_len + extra];
      foreach (pkt[k])
         pkt[k] = 8'($urandom);

      if (kind != PKT_NOISE) begin
         pkt[0] = {pkt[0][7:4], hdr_nib};
         id_at  = hdr_len + ID_OFFSET;
         case (kind)
            PKT_ECHO: pkt[hdr_len] = echo_code;
            PKT_TIME_EXCEEDED: begin
               pkt[hdr_len] = ttl_code;
               pkt[hdr_len + ICMP_HDR_BYTES] =
                  {pkt[hdr_len + ICMP_HDR_BYTES][7:4], inner_nib};
               id_at = hdr_len + ICMP_HDR_BYTES + inner_len + ID_OFFSET;
            end
            default: ;
         endcase
         {pkt[id_at], pkt[id_at + 1], pkt[id_at + 2], pkt[id_at + 3]} = {id_val, seq_val};
      end

      total = cut ? $urandom_range(1, full_len) : full_len + extra;
      for (i = 0; i < total; i++)
         queue_byte(pkt[i], i == total - 1);
   endtask

   task automatic queue_random_packets(input int count);
      int n;
      int roll;
      pkt_kind_type kind;
      @(negedge clock);
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40)      kind = PKT_ECHO;
         else if (roll < 75) kind = PKT_TIME_EXCEEDED;
         else if (roll < 85) kind = PKT_OTHER;
         else                kind = PKT_NOISE;
         queue_packet(kind, $urandom_range(0, 8), $urandom_range(0, 4) == 0);
      end
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // byte driver with random gaps between transactions
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (parse_reply_byte(req_payload, predicted_reply))
               expected_replies.push_back(predicted_reply);
            gap_left = pick_gap(req_calm);
         end
         if (!req_valid || req_ready) begin
            if (gap_left == 0 && pending_bytes.size() != 0) begin
               req_payload <= pending_bytes.pop_front();
               req_valid   <= 1'b1;
            end else begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_replies.size() == 0) begin
               error_count++;
               $display("%0t: result mismatch, expected none, got %p", $time, rsp_payload);
            end else begin
               reply_want = expected_replies.pop_front();
               check_field("status", reply_want.status, rsp_payload.status);
               check_field("matched", reply_want.matched, rsp_payload.matched);
               check_field("was_time_exceeded", reply_want.was_time_exceeded,
                           rsp_payload.was_time_exceeded);
               check_field("source_ip", reply_want.source_ip, rsp_payload.source_ip);
               check_field("round_trip_ms", reply_want.round_trip_ms,
                           rsp_payload.round_trip_ms);
            end
         end

         // one long hold-off so the block backs up into the byte stream
         if (!long_hold_done && results_checked == HOLD_AT_RESULT) begin
            long_hold_done = 1'b1;
            hold_left      = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ((rsp_valid && rsp_ready) || $urandom_range(0, 7) == 0)
               stall_left = pick_gap(rsp_calm);
         end
      end
   end

   // stimulus sequence
   initial begin
      clear_packet_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte packet, zero-length echo header, cut time exceeded
      @(negedge clock);
      pending_bytes.push_back('{data_byte: 8'hFF, last_byte: 1'b1, now_ms: 32'hFFFF_FFFF});
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hAA, 1'b0);
      queue_byte(8'h55, 1'b0);
      queue_byte(8'hFF, 1'b0);
      repeat (3) queue_byte(8'h00, 1'b0);
      pending_bytes.push_back('{data_byte: 8'h00, last_byte: 1'b1, now_ms: 32'h0});
      queue_byte(8'h41, 1'b0);
      repeat (3) queue_byte(8'($urandom), 1'b0);
      queue_byte(ttl_code, 1'b0);
      repeat (7) queue_byte(8'($urandom), 1'b0);
      queue_byte(8'h40, 1'b0);
      queue_byte(8'($urandom), 1'b1);
      wait_drained();

      // usual type codes, random expectations, junk in unused data bits
      write_csr(CSR_EXPECTED_ID, $urandom);
      write_csr(CSR_EXPECTED_SEQ, $urandom);
      write_csr(CSR_SEND_TIME, $urandom);
      write_csr(CSR_ECHO_REPLY_TYPE, {24'($urandom), 8'h00});
      write_csr(CSR_TIME_EXCEEDED_TYPE, {24'($urandom), TIME_EXCEEDED_RESET});
      queue_random_packets(9);
      wait_drained();

      // all ones, both type codes equal so echo wins
      write_csr(CSR_EXPECTED_ID, '1);
      write_csr(CSR_EXPECTED_SEQ, '1);
      write_csr(CSR_SEND_TIME, '1);
      write_csr(CSR_ECHO_REPLY_TYPE, '1);
      write_csr(CSR_TIME_EXCEEDED_TYPE, '1);
      queue_random_packets(9);
      wait_drained();

      // all zero but the time exceeded type (0x80), sender pauses halfway until every result is back
      write_csr(CSR_EXPECTED_ID, '0);
      write_csr(CSR_EXPECTED_SEQ, '0);
      write_csr(CSR_SEND_TIME, '0);
      write_csr(CSR_ECHO_REPLY_TYPE, '0);
      write_csr(CSR_TIME_EXCEEDED_TYPE, 32'h80);
      queue_random_packets(3);
      wait_drained();
      queue_random_packets(3);
      wait_drained();

      // random registers
      write_csr(CSR_EXPECTED_ID, $urandom);
      write_csr(CSR_EXPECTED_SEQ, $urandom);
      write_csr(CSR_SEND_TIME, $urandom);
      write_csr(CSR_ECHO_REPLY_TYPE, $urandom);
      write_csr(CSR_TIME_EXCEEDED_TYPE, $urandom);
      queue_random_packets(3);
      wait_drained();
      repeat (8) @(posedge clock);

      if (expected_replies.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, expected_replies.size());
      end
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/irm_pkg.sv
hw/rtl/icmp_reply_matcher.sv
verif/tb_icmp_reply_matcher.sv
